>>> rtl/positional_array_list_unit_macros.svh
// Assertion helpers for the positional array list unit.
// Both sample on clk and stay quiet while rst is high.
`ifndef POSITIONAL_ARRAY_LIST_UNIT_MACROS_SVH
`define POSITIONAL_ARRAY_LIST_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define PAL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PAL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/pal_pkg.sv
`default_nettype none

package pal_pkg;

  localparam int CAPACITY    = 64;
  localparam int ADDR_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int DATA_W      = 32;
  localparam int POS_W       = 7;
  localparam int CNT_FIELD_W = 7;

  localparam logic [2:0] REQ_INSERT_AT  = 3'd0;
  localparam logic [2:0] REQ_APPEND     = 3'd1;
  localparam logic [2:0] REQ_REMOVE_AT  = 3'd2;
  localparam logic [2:0] REQ_REMOVE_LST = 3'd3;
  localparam logic [2:0] REQ_REMOVE_ALL = 3'd4;
  localparam logic [2:0] REQ_READ_AT    = 3'd5;
  localparam logic [2:0] REQ_READ_LST   = 3'd6;
  localparam logic [2:0] REQ_FIND_ALL   = 3'd7;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_RANGE   = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;
  localparam logic [1:0] STAT_NOMATCH = 2'd3;

  typedef struct packed {
    logic [2:0]              req_type;
    logic [POS_W-1:0]        position;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [1:0]              status;
    logic [CNT_FIELD_W-1:0]  entry_count;
    logic                    last;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/pal_ram.sv
`default_nettype none

module pal_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/pal_ctrl.sv
`default_nettype none

module pal_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire pal_pkg::req_t               request,
  output logic                             busy,
  output logic                             done,
  output pal_pkg::res_t                    result,
  output logic                             ram_re,
  output logic [pal_pkg::ADDR_W-1:0]       ram_raddr,
  output logic                             ram_we,
  output logic [pal_pkg::ADDR_W-1:0]       ram_waddr,
  output logic [pal_pkg::DATA_W-1:0]       ram_wdata,
  input  wire logic [pal_pkg::DATA_W-1:0]  ram_rdata
);

  import pal_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]        state;
  logic [2:0]        op;
  logic [DATA_W-1:0] val;
  logic [ADDR_W-1:0] pos;
  logic [1:0]        stat;
  logic [CNT_W-1:0]  count;
  logic [ADDR_W-1:0] rd;
  logic [ADDR_W-1:0] rd_last;
  logic              desc;
  logic              issuing;
  logic              rv;
  logic [ADDR_W-1:0] ra;
  logic [CNT_W-1:0]  n;
  logic [CNT_W-1:0]  match_cnt;
  logic              hold;
  logic [ADDR_W-1:0] hold_idx;
  logic [DATA_W-1:0] cap;

  // accept-time decode
  logic [POS_W-1:0]  eff_pos;
  logic [POS_W-1:0]  cnt_ext;
  logic [CNT_W-1:0]  cnt_m1;
  logic [1:0]        a_stat;
  logic              a_scan;
  logic              a_desc;
  logic [ADDR_W-1:0] a_pos;
  logic [ADDR_W-1:0] a_first;
  logic [ADDR_W-1:0] a_last;

  logic is_ins;
  logic is_rem;
  logic is_read;
  logic hit;
  logic accept;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign cnt_ext = POS_W'(count);
  assign cnt_m1  = count - 1'b1;
  assign is_ins  = (op == REQ_INSERT_AT) || (op == REQ_APPEND);
  assign is_rem  = (op == REQ_REMOVE_AT) || (op == REQ_REMOVE_LST);
  assign is_read = (op == REQ_READ_AT) || (op == REQ_READ_LST);
  assign hit     = (ram_rdata == val);

  always_comb begin
    eff_pos = (request.req_type == REQ_APPEND) ? cnt_ext : request.position;
    a_stat  = STAT_OK;
    a_scan  = 1'b0;
    a_desc  = 1'b0;
    a_pos   = eff_pos[ADDR_W-1:0];
    a_first = '0;
    a_last  = cnt_m1[ADDR_W-1:0];
    unique case (request.req_type)
      REQ_INSERT_AT, REQ_APPEND: begin
        a_first = cnt_m1[ADDR_W-1:0];
        a_last  = eff_pos[ADDR_W-1:0];
        a_desc  = 1'b1;
        if (eff_pos > cnt_ext) begin
          a_stat = STAT_RANGE;
        end else if (count >= CNT_W'(CAPACITY)) begin
          a_stat = STAT_FULL;
        end else begin
          a_scan = (eff_pos < cnt_ext);
        end
      end
      REQ_REMOVE_AT, REQ_READ_AT: begin
        a_first = request.position[ADDR_W-1:0];
        if (request.req_type == REQ_READ_AT) begin
          a_last = request.position[ADDR_W-1:0];
        end
        if (request.position >= cnt_ext) begin
          a_stat = STAT_RANGE;
        end else begin
          a_scan = 1'b1;
        end
      end
      REQ_REMOVE_LST, REQ_READ_LST: begin
        a_pos   = cnt_m1[ADDR_W-1:0];
        a_first = cnt_m1[ADDR_W-1:0];
        if (count == '0) begin
          a_stat = STAT_RANGE;
        end else begin
          a_scan = 1'b1;
        end
      end
      REQ_REMOVE_ALL, REQ_FIND_ALL: begin
        a_scan = (count != '0);
      end
      default: begin
        a_stat = STAT_RANGE;
      end
    endcase
  end

  // RAM side: reads run ahead, writes follow in the cycle after each read on the other side
  always_comb begin
    ram_re    = (state == S_SCAN) && issuing;
    ram_raddr = rd;
    ram_we    = 1'b0;
    ram_waddr = ra;
    ram_wdata = ram_rdata;
    if (state == S_SCAN && rv) begin
      if (is_ins) begin
        ram_we    = 1'b1;
        ram_waddr = ra + 1'b1;
      end else if (is_rem) begin
        ram_we    = (ra != pos);
        ram_waddr = ra - 1'b1;
      end else if (op == REQ_REMOVE_ALL) begin
        ram_we    = !hit;
        ram_waddr = n[ADDR_W-1:0];
      end
    end else if (state == S_FIN && is_ins && stat == STAT_OK) begin
      ram_we    = 1'b1;
      ram_waddr = pos;
      ram_wdata = val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      issuing <= 1'b0;
      rv      <= 1'b0;
      done    <= 1'b0;
      hold    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op        <= request.req_type;
            val       <= request.value;
            pos       <= a_pos;
            stat      <= a_stat;
            rd        <= a_first;
            rd_last   <= a_last;
            desc      <= a_desc;
            issuing   <= a_scan;
            rv        <= 1'b0;
            n         <= '0;
            match_cnt <= '0;
            hold      <= 1'b0;
            state     <= a_scan ? S_SCAN : S_FIN;
          end
        end
        S_SCAN: begin
          rv <= issuing;
          if (issuing) begin
            ra <= rd;
            if (rd == rd_last) begin
              issuing <= 1'b0;
            end else begin
              rd <= desc ? rd - 1'b1 : rd + 1'b1;
            end
          end
          if (rv) begin
            if ((is_rem && ra == pos) || is_read) begin
              cap <= ram_rdata;
            end
            if (op == REQ_REMOVE_ALL) begin
              if (hit) begin
                match_cnt <= match_cnt + 1'b1;
              end else begin
                n <= n + 1'b1;
              end
            end
            // find: release the held match once a later one turns up
            if (op == REQ_FIND_ALL && hit) begin
              if (hold) begin
                result <= '{data: DATA_W'(hold_idx), status: STAT_OK,
                            entry_count: CNT_FIELD_W'(count), last: 1'b0};
                done   <= 1'b1;
              end
              hold     <= 1'b1;
              hold_idx <= ra;
            end
            if (!issuing) begin
              state <= S_FIN;
            end
          end
        end
        S_FIN: begin
          state <= S_IDLE;
          done  <= 1'b1;
          if (stat != STAT_OK) begin
            result <= '{data: '0, status: stat,
                        entry_count: CNT_FIELD_W'(count), last: 1'b1};
          end else if (is_ins) begin
            count  <= count + 1'b1;
            result <= '{data: '0, status: STAT_OK,
                        entry_count: CNT_FIELD_W'(count + 1'b1), last: 1'b1};
          end else if (is_rem) begin
            count  <= cnt_m1;
            result <= '{data: cap, status: STAT_OK,
                        entry_count: CNT_FIELD_W'(cnt_m1), last: 1'b1};
          end else if (is_read) begin
            result <= '{data: cap, status: STAT_OK,
                        entry_count: CNT_FIELD_W'(count), last: 1'b1};
          end else if (op == REQ_REMOVE_ALL) begin
            if (count != '0) begin
              count <= n;
            end
            result <= '{data: DATA_W'(match_cnt), status: STAT_OK,
                        entry_count: CNT_FIELD_W'((count != '0) ? n : count),
                        last: 1'b1};
          end else if (hold) begin
            result <= '{data: DATA_W'(hold_idx), status: STAT_OK,
                        entry_count: CNT_FIELD_W'(count), last: 1'b1};
          end else begin
            result <= '{data: '0, status: STAT_NOMATCH,
                        entry_count: CNT_FIELD_W'(count), last: 1'b1};
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/positional_array_list_unit.sv
// An item that reads or moves no entry goes from accept straight to the final
// state, which registers the result; otherwise the entries are walked first (at
// most CAPACITY of them). A new item is taken only while not busy, and busy falls
// with the final result. Find-all holds each match until the next one is read.
// Reset clears the entry count and the sequencer; RAM contents stay as they are.
`default_nettype none

`include "positional_array_list_unit_macros.svh"

module positional_array_list_unit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire pal_pkg::req_t request,
  output logic               busy,
  output logic               done,
  output pal_pkg::res_t      result
);

  import pal_pkg::*;

  logic              ram_re;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_raddr;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [DATA_W-1:0] ram_rdata;

  pal_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pal_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .request   (request),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_rdata (ram_rdata)
  );

  `PAL_ASSERT_SAME(a_last_frees, done && result.last, !busy, "final result while busy")
  `PAL_ASSERT_SAME(a_mid_busy, done && !result.last, busy, "partial result after idle")
  `PAL_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
  `PAL_ASSERT_SAME(a_full_count, done && (result.status == STAT_FULL), result.entry_count == CNT_FIELD_W'(CAPACITY), "full status below capacity")

endmodule

`default_nettype wire
